// ===== sv/lsra_pkg.sv =====
package lsra_pkg;

   localparam int unsigned SEQ_BITS  = 32;
   localparam int unsigned PHYS_BITS = 5;
   localparam int unsigned MASK_BITS = 32;
   localparam int unsigned CSR_BITS  = 2;

   localparam logic [MASK_BITS-1:0] INT_POOL_RESET     = 32'hFFFF_FEE0;
   localparam logic [MASK_BITS-1:0] FLOAT_POOL_RESET   = 32'hFFFF_FFFF;
   localparam logic [MASK_BITS-1:0] INT_CALLEE_RESET   = 32'h0FFC_0300;
   localparam logic [MASK_BITS-1:0] FLOAT_CALLEE_RESET = 32'h0FFC_0300;

   localparam logic [CSR_BITS-1:0] CSR_INT_POOL     = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_FLOAT_POOL   = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_INT_CALLEE   = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_FLOAT_CALLEE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DECIDE,
      ST_EVICT
   } state_type;

   // Control from the sequencer to the candidate scan unit.
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [PHYS_BITS-1:0] lowest_set(input logic [MASK_BITS-1:0] v);
      logic [PHYS_BITS-1:0] r;
      r = '0;
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = PHYS_BITS'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/lsra_if.sv =====
interface lsra_req_if #(
   parameter int VREG_BITS = 16,
   parameter int TIME_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic                 first_of_function;
   logic [VREG_BITS-1:0] virtual_register;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] end_time;
   logic                 is_float;

   modport source (
      output valid, first_of_function, virtual_register, start_time, end_time, is_float,
      input  ready
   );
   modport sink (
      input  valid, first_of_function, virtual_register, start_time, end_time, is_float,
      output ready
   );
endinterface

interface lsra_rsp_if #(
   parameter int VREG_BITS = 16,
   parameter int SLOT_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [VREG_BITS-1:0] out_virtual_register;
   logic                 spilled;
   logic [4:0]           physical_index;
   logic                 out_is_float;
   logic [SLOT_BITS-1:0] spill_slot;
   logic                 last;

   modport source (
      output valid, out_virtual_register, spilled, physical_index, out_is_float,
             spill_slot, last,
      input  ready
   );
   modport sink (
      input  valid, out_virtual_register, spilled, physical_index, out_is_float,
             spill_slot, last,
      output ready
   );
endinterface

// ===== sv/linear_scan_register_allocator_top.sv =====
// Linear-scan register allocator.
// Live intervals arrive on req_bus, already sorted by start time, one transfer
// per interval. Each interval yields one decision on rsp_bus, or two when an
// active value is evicted: the evicted virtual register (spilled) comes first
// and the current interval's assignment follows with last set.
// After an interval is accepted the block walks the active table, one entry of
// each class per cycle in a single shared compare pass, then passes through a
// drain state and a decide state that loads the first result into the result
// register. The block takes a new interval only once it is back in idle, after
// the decision, or after the second result when an eviction produces one. The
// walk over the table memories sets the pace of the block.
// The csr_ port writes the pool and callee-saved masks; write them only while
// the block is idle. Reset restores the default masks, empties the active
// table and clears the sequence and spill slot counters.
// When the receiver stalls, the result register holds its value; the block may
// accept and walk the next interval meanwhile, but waits before its decision
// until the pending result has been transferred.
module linear_scan_register_allocator_top #(
   parameter int REGS_PER_CLASS = 32,
   parameter int VREG_BITS      = 16,
   parameter int TIME_BITS      = 16,
   parameter int SLOT_BITS      = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lsra_req_if.sink                              req_bus,
   lsra_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [lsra_pkg::CSR_BITS-1:0]         csr_index,
   input  logic [lsra_pkg::MASK_BITS-1:0]        csr_write_data
);

   localparam int IDX_BITS  = (REGS_PER_CLASS > 1) ? $clog2(REGS_PER_CLASS) : 1;
   localparam int WORD_BITS = TIME_BITS + VREG_BITS + lsra_pkg::SEQ_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(REGS_PER_CLASS - 1);
   localparam logic [lsra_pkg::MASK_BITS-1:0] LANES =
      lsra_pkg::MASK_BITS'((64'd1 << REGS_PER_CLASS) - 64'd1);

   // Configuration registers.
   logic [lsra_pkg::MASK_BITS-1:0] int_pool_ff, float_pool_ff;
   logic [lsra_pkg::MASK_BITS-1:0] int_callee_ff, float_callee_ff;

   // Sequencer and item registers.
   lsra_pkg::state_type state_ff, state_in;
   logic [IDX_BITS-1:0]  walk_ff, walk_in;
   logic                 proc_valid_ff, proc_valid_in;
   logic [IDX_BITS-1:0]  proc_idx_ff;
   logic [VREG_BITS-1:0] vreg_ff;
   logic [TIME_BITS-1:0] start_ff, end_ff;
   logic                 cls_ff;

   // Allocation state: valid bits in flops, entry contents in the memories.
   logic [1:0][REGS_PER_CLASS-1:0] valid_ff, valid_in;
   logic [lsra_pkg::SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [SLOT_BITS-1:0]           slot_ff, slot_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VREG_BITS-1:0] rsp_vreg_ff, rsp_vreg_in;
   logic                 rsp_spilled_ff, rsp_spilled_in;
   logic [lsra_pkg::PHYS_BITS-1:0] rsp_phys_ff, rsp_phys_in;
   logic [SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_cls_ff;
   logic                 rsp_load;

   logic req_fire, out_free, decide_fire, evict_fire;
   logic [WORD_BITS-1:0] rd_data [2];
   logic [1:0]           expired;
   logic [1:0][TIME_BITS-1:0] rd_end;

   logic [lsra_pkg::MASK_BITS-1:0] pool, callee, busy, freeset, pick;
   logic [lsra_pkg::PHYS_BITS-1:0] pick_reg;
   logic                           have_free, do_evict;

   logic                 ram_wr;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;

   lsra_pkg::scan_ctl_type scan_ctl;
   logic                 scan_found;
   logic [TIME_BITS-1:0] best_end;
   logic [VREG_BITS-1:0] best_vreg;
   logic [IDX_BITS-1:0]  best_idx;
   logic [WORD_BITS-1:0] cls_word;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         int_pool_ff     <= lsra_pkg::INT_POOL_RESET;
         float_pool_ff   <= lsra_pkg::FLOAT_POOL_RESET;
         int_callee_ff   <= lsra_pkg::INT_CALLEE_RESET;
         float_callee_ff <= lsra_pkg::FLOAT_CALLEE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lsra_pkg::CSR_INT_POOL:     int_pool_ff     <= csr_write_data;
            lsra_pkg::CSR_FLOAT_POOL:   float_pool_ff   <= csr_write_data;
            lsra_pkg::CSR_INT_CALLEE:   int_callee_ff   <= csr_write_data;
            lsra_pkg::CSR_FLOAT_CALLEE: float_callee_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Entry memories, one per register class, read together during the walk.
   for (genvar c = 0; c < 2; c++) begin : g_class
      lsra_ram #(
         .WIDTH (WORD_BITS),
         .DEPTH (REGS_PER_CLASS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr && (cls_ff == 1'(c))),
         .wr_addr (ram_wr_addr),
         .wr_data (ram_wr_data),
         .rd_addr (walk_ff),
         .rd_data (rd_data[c])
      );

      assign rd_end[c]  = rd_data[c][WORD_BITS-1 -: TIME_BITS];
      assign expired[c] = proc_valid_ff && valid_ff[c][proc_idx_ff] &&
                          (rd_end[c] < start_ff);
   end

   // The scan unit sees only live entries of the current class.
   assign cls_word      = rd_data[cls_ff];
   assign scan_ctl.clear = req_fire;
   assign scan_ctl.step  = proc_valid_ff && valid_ff[cls_ff][proc_idx_ff] &&
                           !expired[cls_ff];

   lsra_scan #(
      .TIME_BITS (TIME_BITS),
      .VREG_BITS (VREG_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .entry_end  (cls_word[WORD_BITS-1 -: TIME_BITS]),
      .entry_vreg (cls_word[lsra_pkg::SEQ_BITS +: VREG_BITS]),
      .entry_seq  (cls_word[lsra_pkg::SEQ_BITS-1:0]),
      .entry_idx  (proc_idx_ff),
      .found      (scan_found),
      .best_end   (best_end),
      .best_vreg  (best_vreg),
      .best_idx   (best_idx)
   );

   // Free-register choice once the walk has expired old entries.
   always_comb begin
      pool   = (cls_ff ? float_pool_ff : int_pool_ff) & LANES;
      callee = cls_ff ? float_callee_ff : int_callee_ff;
      busy   = lsra_pkg::MASK_BITS'(valid_ff[cls_ff]);
      freeset = pool & ~busy;
      pick   = ((freeset & ~callee) != '0) ? (freeset & ~callee) : freeset;
      pick_reg  = lsra_pkg::lowest_set(pick);
      have_free = (freeset != '0);
      do_evict  = !have_free && scan_found && (best_end > end_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsra_pkg::ST_IDLE: begin
            if (req_fire) state_in = lsra_pkg::ST_WALK;
         end
         lsra_pkg::ST_WALK: begin
            if (walk_ff == LAST_IDX) state_in = lsra_pkg::ST_DRAIN;
         end
         lsra_pkg::ST_DRAIN: begin
            state_in = lsra_pkg::ST_DECIDE;
         end
         lsra_pkg::ST_DECIDE: begin
            if (out_free) state_in = do_evict ? lsra_pkg::ST_EVICT : lsra_pkg::ST_IDLE;
         end
         lsra_pkg::ST_EVICT: begin
            if (out_free) state_in = lsra_pkg::ST_IDLE;
         end
         default: state_in = lsra_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      decide_fire   = 1'b0;
      evict_fire    = 1'b0;
      walk_in       = walk_ff;
      proc_valid_in = 1'b0;
      case (state_ff)
         lsra_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            walk_in       = '0;
         end
         lsra_pkg::ST_WALK: begin
            proc_valid_in = 1'b1;
            walk_in       = walk_ff + 1'b1;
         end
         lsra_pkg::ST_DRAIN: begin
         end
         lsra_pkg::ST_DECIDE: begin
            decide_fire = out_free;
         end
         lsra_pkg::ST_EVICT: begin
            evict_fire = out_free;
         end
         default: begin
         end
      endcase
   end

   // Table writes, counters and result loading.
   always_comb begin
      valid_in    = valid_ff;
      seq_in      = seq_ff;
      slot_in     = slot_ff;
      ram_wr      = 1'b0;
      ram_wr_addr = have_free ? pick_reg[IDX_BITS-1:0] : best_idx;
      ram_wr_data = {end_ff, vreg_ff, seq_ff};

      rsp_load       = 1'b0;
      rsp_vreg_in    = vreg_ff;
      rsp_spilled_in = 1'b0;
      rsp_phys_in    = '0;
      rsp_slot_in    = '0;
      rsp_last_in    = 1'b1;

      if (req_fire && req_bus.first_of_function) begin
         valid_in = '0;
         seq_in   = '0;
         slot_in  = '0;
      end

      for (int c = 0; c < 2; c++) begin
         if (expired[c]) valid_in[c][proc_idx_ff] = 1'b0;
      end

      if (decide_fire) begin
         rsp_load = 1'b1;
         if (have_free) begin
            ram_wr = 1'b1;
            valid_in[cls_ff][pick_reg[IDX_BITS-1:0]] = 1'b1;
            seq_in      = seq_ff + 1'b1;
            rsp_phys_in = pick_reg;
         end else begin
            // Evicted value or the interval itself goes to the next slot.
            if (slot_ff != '1) slot_in = slot_ff + 1'b1;
            rsp_spilled_in = 1'b1;
            rsp_slot_in    = slot_ff;
            if (do_evict) begin
               ram_wr      = 1'b1;
               seq_in      = seq_ff + 1'b1;
               rsp_vreg_in = best_vreg;
               rsp_last_in = 1'b0;
            end
         end
      end

      if (evict_fire) begin
         rsp_load    = 1'b1;
         rsp_phys_in = lsra_pkg::PHYS_BITS'(best_idx);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsra_pkg::ST_IDLE;
         walk_ff       <= '0;
         proc_valid_ff <= 1'b0;
         valid_ff      <= '0;
         seq_ff        <= '0;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         seq_ff        <= seq_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The class travels with the result, since the next interval may be
   // accepted while this result still waits for the receiver.
   always_ff @(posedge clock) begin
      proc_idx_ff <= walk_ff;
      if (req_fire) begin
         vreg_ff  <= req_bus.virtual_register;
         start_ff <= req_bus.start_time;
         end_ff   <= req_bus.end_time;
         cls_ff   <= req_bus.is_float;
      end
      if (rsp_load) begin
         rsp_vreg_ff    <= rsp_vreg_in;
         rsp_spilled_ff <= rsp_spilled_in;
         rsp_phys_ff    <= rsp_phys_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_cls_ff     <= cls_ff;
      end
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.out_virtual_register = rsp_vreg_ff;
   assign rsp_bus.spilled              = rsp_spilled_ff;
   assign rsp_bus.physical_index       = rsp_phys_ff;
   assign rsp_bus.out_is_float         = rsp_cls_ff;
   assign rsp_bus.spill_slot           = rsp_slot_ff;
   assign rsp_bus.last                 = rsp_last_ff;

endmodule

// ===== sv/lsra_ram.sv =====
module lsra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lsra_scan.sv =====
// Tracks the same-class active entry that ends latest, earliest inserted on ties.
module lsra_scan #(
   parameter int TIME_BITS = 16,
   parameter int VREG_BITS = 16,
   parameter int IDX_BITS  = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsra_pkg::scan_ctl_type        ctl,
   input  logic [TIME_BITS-1:0]          entry_end,
   input  logic [VREG_BITS-1:0]          entry_vreg,
   input  logic [lsra_pkg::SEQ_BITS-1:0] entry_seq,
   input  logic [IDX_BITS-1:0]           entry_idx,
   output logic                          found,
   output logic [TIME_BITS-1:0]          best_end,
   output logic [VREG_BITS-1:0]          best_vreg,
   output logic [IDX_BITS-1:0]           best_idx
);

   logic                          found_ff;
   logic [TIME_BITS-1:0]          best_end_ff;
   logic [VREG_BITS-1:0]          best_vreg_ff;
   logic [lsra_pkg::SEQ_BITS-1:0] best_seq_ff;
   logic [IDX_BITS-1:0]           best_idx_ff;
   logic                          better;

   assign better = !found_ff || (entry_end > best_end_ff) ||
                   ((entry_end == best_end_ff) && (entry_seq < best_seq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (ctl.step && better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step && better) begin
         best_end_ff  <= entry_end;
         best_vreg_ff <= entry_vreg;
         best_seq_ff  <= entry_seq;
         best_idx_ff  <= entry_idx;
      end
   end

   assign found     = found_ff;
   assign best_end  = best_end_ff;
   assign best_vreg = best_vreg_ff;
   assign best_idx  = best_idx_ff;

endmodule

// ===== tb/linear_scan_register_allocator_top_test.sv =====
module linear_scan_register_allocator_top_test;

   // Roughly four times the slowest legal run: every interval evicting, every
   // result stalled for the longest receiver stall, every send after the
   // longest sender gap.
   localparam int CYCLE_LIMIT = 2_000_000;

   // Cycles to let pass once the last expected decision has been seen.
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic        first_of_function;
      logic [15:0] virtual_register;
      logic [15:0] start_time;
      logic [15:0] end_time;
      logic        is_float;
   } interval_type;

   typedef struct {
      logic [15:0]                    vreg;
      logic                           spilled;
      logic [lsra_pkg::PHYS_BITS-1:0] phys;
      logic                           is_float;
      logic [15:0]                    slot;
      logic                           last;
   } decision_type;

   logic clock = 1'b0;
   logic reset;

   logic                           csr_write_enable;
   logic [lsra_pkg::CSR_BITS-1:0]  csr_index;
   logic [lsra_pkg::MASK_BITS-1:0] csr_write_data;

   lsra_req_if #(.VREG_BITS(16), .TIME_BITS(16)) req_bus ();
   lsra_rsp_if #(.VREG_BITS(16), .SLOT_BITS(16)) rsp_bus ();

   linear_scan_register_allocator_top #(
      .REGS_PER_CLASS(32),
      .VREG_BITS     (16),
      .TIME_BITS     (16),
      .SLOT_BITS     (16)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Allocator shadow state. The table is indexed by class * 32 + register,
   // the same layout the block uses for its active entries.
   // ------------------------------------------------------------------------
   logic [lsra_pkg::MASK_BITS-1:0] int_pool     = lsra_pkg::INT_POOL_RESET;
   logic [lsra_pkg::MASK_BITS-1:0] float_pool   = lsra_pkg::FLOAT_POOL_RESET;
   logic [lsra_pkg::MASK_BITS-1:0] int_callee   = lsra_pkg::INT_CALLEE_RESET;
   logic [lsra_pkg::MASK_BITS-1:0] float_callee = lsra_pkg::FLOAT_CALLEE_RESET;

   bit          live_valid [64];
   logic [15:0] live_end   [64];
   logic [15:0] live_vreg  [64];
   logic [31:0] live_seq   [64];
   logic [31:0] claim_count     = '0;
   logic [15:0] next_spill_slot = '0;

   // Decisions the block still owes us, oldest first.
   decision_type pending_decisions[$];

   int  failures    = 0;
   int  cycle_count = 0;
   bit  sender_idles    = 1'b1;
   bit  receiver_stalls = 1'b1;

   function automatic void expect_decision(input logic [15:0] vreg, input logic spilled,
                                           input int phys, input logic flt,
                                           input logic [15:0] slot, input logic last);
      decision_type d;
      d.vreg     = vreg;
      d.spilled  = spilled;
      d.phys     = lsra_pkg::PHYS_BITS'(phys);
      d.is_float = flt;
      d.slot     = slot;
      d.last     = last;
      pending_decisions.push_back(d);
   endfunction

   // The spill slot counter sticks at its top value instead of wrapping.
   function automatic logic [15:0] take_spill_slot();
      logic [15:0] s;
      s = next_spill_slot;
      if (next_spill_slot != 16'hFFFF) begin
         next_spill_slot = next_spill_slot + 16'd1;
      end
      return s;
   endfunction

   function automatic void claim_register(input int idx, input interval_type iv);
      live_valid[idx] = 1'b1;
      live_vreg[idx]  = iv.virtual_register;
      live_end[idx]   = iv.end_time;
      live_seq[idx]   = claim_count;
      claim_count     = claim_count + 32'd1;
   endfunction

   // Works out the decisions for one accepted interval and queues them.
   function automatic void allocate_interval(input interval_type iv);
      logic [31:0] pool;
      logic [31:0] callee;
      logic [31:0] busy;
      logic [31:0] freeset;
      logic [31:0] pick;
      logic [15:0] victim;
      logic [15:0] slot;
      int          base;
      int          r;
      int          idx;
      int          best;
      bit          found;

      if (iv.first_of_function) begin
         foreach (live_valid[i]) live_valid[i] = 1'b0;
         claim_count     = '0;
         next_spill_slot = '0;
      end

      // Expiry covers both classes, not only the class of this interval.
      for (int i = 0; i < 64; i++) begin
         if (live_valid[i] && live_end[i] < iv.start_time) begin
            live_valid[i] = 1'b0;
         end
      end

      base   = iv.is_float ? 32 : 0;
      pool   = iv.is_float ? float_pool : int_pool;
      callee = iv.is_float ? float_callee : int_callee;
      busy   = '0;
      for (int i = 0; i < 32; i++) begin
         busy[i] = live_valid[base + i];
      end
      freeset = pool & ~busy;

      if (freeset != '0) begin
         pick = ((freeset & ~callee) != '0) ? (freeset & ~callee) : freeset;
         r = 0;
         while (!pick[r]) begin
            r++;
         end
         claim_register(base + r, iv);
         expect_decision(iv.virtual_register, 1'b0, r, iv.is_float, '0, 1'b1);
         return;
      end

      // No free register: look for the same-class entry that ends last,
      // the earliest inserted one winning a tie.
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < 32; i++) begin
         idx = base + i;
         if (live_valid[idx] &&
             (!found || live_end[idx] > live_end[best] ||
              (live_end[idx] == live_end[best] && live_seq[idx] < live_seq[best]))) begin
            found = 1'b1;
            best  = idx;
         end
      end

      if (found && live_end[best] > iv.end_time) begin
         victim = live_vreg[best];
         slot   = take_spill_slot();
         expect_decision(victim, 1'b1, 0, iv.is_float, slot, 1'b0);
         live_valid[best] = 1'b0;
         claim_register(best, iv);
         expect_decision(iv.virtual_register, 1'b0, best - base, iv.is_float, '0, 1'b1);
      end else begin
         slot = take_spill_slot();
         expect_decision(iv.virtual_register, 1'b1, 0, iv.is_float, slot, 1'b1);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Idle and stall lengths: mostly short ones, now and then a long one.
   // ------------------------------------------------------------------------
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(20, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic int next_gap();
      if (!sender_idles || $urandom_range(0, 99) >= 30) begin
         return 0;
      end
      return idle_length();
   endfunction

   function automatic interval_type make_interval(input logic first,
                                                  input logic [15:0] vreg,
                                                  input logic [15:0] start,
                                                  input logic [15:0] stop,
                                                  input logic flt);
      interval_type iv;
      iv.first_of_function = first;
      iv.virtual_register  = vreg;
      iv.start_time        = start;
      iv.end_time          = stop;
      iv.is_float          = flt;
      return iv;
   endfunction

   // Drives one interval at the falling edge and holds it until a rising
   // edge sees valid and ready together. Valid stays high afterwards, so a
   // back-to-back send keeps it high; anything else lowers it at the next
   // falling edge before the block can take the item twice.
   task automatic send_interval(input interval_type iv);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.first_of_function = iv.first_of_function;
      req_bus.virtual_register  = iv.virtual_register;
      req_bus.start_time        = iv.start_time;
      req_bus.end_time          = iv.end_time;
      req_bus.is_float          = iv.is_float;
      req_bus.valid             = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      allocate_interval(iv);
   endtask

   // Stops sending and waits until every queued decision has been seen.
   task automatic wait_for_decisions();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_decisions.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Mask writes happen only with the block idle, after a short settle.
   task automatic write_mask(input logic [lsra_pkg::CSR_BITS-1:0] index,
                             input logic [lsra_pkg::MASK_BITS-1:0] value);
      wait_for_decisions();
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (index)
         lsra_pkg::CSR_INT_POOL:     int_pool     = value;
         lsra_pkg::CSR_FLOAT_POOL:   float_pool   = value;
         lsra_pkg::CSR_INT_CALLEE:   int_callee   = value;
         lsra_pkg::CSR_FLOAT_CALLEE: float_callee = value;
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------------

   // Field extremes under the reset masks: both classes, zero and all-ones
   // identifiers and times, expiry at start one, an interval that ends
   // exactly at its start, and an end below its start.
   task automatic test_field_extremes();
      send_interval(make_interval(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_interval(make_interval(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
      send_interval(make_interval(1'b0, 16'h1234, 16'h0001, 16'hFFFF, 1'b0));
      send_interval(make_interval(1'b0, 16'hABCD, 16'hFFFF, 16'hFFFF, 1'b1));
      send_interval(make_interval(1'b1, 16'h5555, 16'hFFFF, 16'h0000, 1'b1));
   endtask

   // With every register callee-saved the lowest free one is taken; with
   // none callee-saved and the whole file in the pool, x0 comes first.
   task automatic test_callee_order();
      write_mask(lsra_pkg::CSR_INT_CALLEE, 32'hFFFF_FFFF);
      send_interval(make_interval(1'b1, 16'h0010, 16'h0000, 16'h0100, 1'b0));
      send_interval(make_interval(1'b0, 16'h0011, 16'h0001, 16'h0100, 1'b0));
      send_interval(make_interval(1'b0, 16'h0012, 16'h0002, 16'h0100, 1'b0));
      write_mask(lsra_pkg::CSR_INT_CALLEE, 32'h0000_0000);
      write_mask(lsra_pkg::CSR_INT_POOL, 32'hFFFF_FFFF);
      send_interval(make_interval(1'b1, 16'h0020, 16'h0000, 16'h0100, 1'b0));
      send_interval(make_interval(1'b0, 16'h0021, 16'h0000, 16'h0100, 1'b0));
   endtask

   // Two float registers only (f0 and f31). Covers a spill on an equal end,
   // a spill when the candidate ends sooner, eviction with the earliest
   // inserted entry winning a tie, a second eviction, and expiry of both.
   task automatic test_eviction_rules();
      write_mask(lsra_pkg::CSR_FLOAT_POOL, 32'h8000_0001);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, 32'hFFFF_FFFF);
      send_interval(make_interval(1'b1, 16'h0101, 16'd0, 16'd100, 1'b1));
      send_interval(make_interval(1'b0, 16'h0102, 16'd0, 16'd100, 1'b1));
      send_interval(make_interval(1'b0, 16'h0103, 16'd1, 16'd100, 1'b1));
      send_interval(make_interval(1'b0, 16'h0104, 16'd2, 16'd200, 1'b1));
      send_interval(make_interval(1'b0, 16'h0105, 16'd3, 16'd50, 1'b1));
      send_interval(make_interval(1'b0, 16'h0106, 16'd4, 16'd60, 1'b1));
      send_interval(make_interval(1'b0, 16'h0107, 16'd61, 16'd70, 1'b1));
   endtask

   // An empty integer pool spills every integer interval; the start of a
   // new function brings the spill slots back to zero.
   task automatic test_empty_pool();
      write_mask(lsra_pkg::CSR_INT_POOL, 32'h0000_0000);
      send_interval(make_interval(1'b0, 16'h0201, 16'd62, 16'd63, 1'b0));
      send_interval(make_interval(1'b1, 16'h0202, 16'd0, 16'd10, 1'b0));
   endtask

   // ------------------------------------------------------------------------
   // Random traffic: mostly well-formed functions (first interval flagged,
   // starts never going backwards), with some noise items mixed in.
   // ------------------------------------------------------------------------
   task automatic run_functions(input int count, input bit drain_pauses);
      int           sent;
      int           length;
      int           t;
      int           e;
      interval_type iv;
      sent = 0;
      while (sent < count) begin
         length = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                              : $urandom_range(1, 40);
         t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
         for (int k = 0; k < length && sent < count; k++) begin
            if ($urandom_range(0, 99) < 5) begin
               iv = make_interval(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1)));
            end else begin
               t = t + (($urandom_range(0, 19) == 0) ? $urandom_range(100, 3000)
                                                     : $urandom_range(0, 4));
               if (t > 65535) begin
                  t = 65535;
               end
               e = t + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 8000)
                                                    : $urandom_range(0, 60));
               if (e > 65535) begin
                  e = 65535;
               end
               if (t > 0 && $urandom_range(0, 29) == 0) begin
                  e = int'($urandom_range(0, t - 1));
               end
               iv = make_interval(k == 0, 16'($urandom_range(0, 65535)), 16'(t), 16'(e),
                                  $urandom_range(0, 99) < 40);
            end
            send_interval(iv);
            sent++;
            if (drain_pauses && $urandom_range(0, 149) == 0) begin
               wait_for_decisions();
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      // Reset masks again, normal idling.
      write_mask(lsra_pkg::CSR_INT_POOL, lsra_pkg::INT_POOL_RESET);
      write_mask(lsra_pkg::CSR_FLOAT_POOL, lsra_pkg::FLOAT_POOL_RESET);
      write_mask(lsra_pkg::CSR_INT_CALLEE, lsra_pkg::INT_CALLEE_RESET);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, lsra_pkg::FLOAT_CALLEE_RESET);
      run_functions(500, 1'b1);

      // Sparse pools keep both classes short of registers, so evictions and
      // self spills are common.
      write_mask(lsra_pkg::CSR_INT_POOL, $urandom & $urandom & $urandom);
      write_mask(lsra_pkg::CSR_FLOAT_POOL, $urandom & $urandom & $urandom);
      write_mask(lsra_pkg::CSR_INT_CALLEE, $urandom);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, $urandom);
      run_functions(500, 1'b1);

      // Full integer file, no float registers at all, and no idling on
      // either side so the block runs back to back.
      write_mask(lsra_pkg::CSR_INT_POOL, 32'hFFFF_FFFF);
      write_mask(lsra_pkg::CSR_FLOAT_POOL, 32'h0000_0000);
      write_mask(lsra_pkg::CSR_INT_CALLEE, 32'h0000_0000);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, 32'h0000_0000);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      run_functions(300, 1'b0);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;

      // Fully random masks.
      write_mask(lsra_pkg::CSR_INT_POOL, $urandom);
      write_mask(lsra_pkg::CSR_FLOAT_POOL, $urandom);
      write_mask(lsra_pkg::CSR_INT_CALLEE, $urandom);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, $urandom);
      run_functions(400, 1'b1);

      // Very small pools with everything callee-saved.
      write_mask(lsra_pkg::CSR_INT_POOL, $urandom & $urandom & $urandom & $urandom);
      write_mask(lsra_pkg::CSR_FLOAT_POOL, $urandom & $urandom & $urandom & $urandom);
      write_mask(lsra_pkg::CSR_INT_CALLEE, 32'hFFFF_FFFF);
      write_mask(lsra_pkg::CSR_FLOAT_CALLEE, 32'hFFFF_FFFF);
      run_functions(300, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge, with random stalls.
   // ------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 99) < 15) begin
            rsp_bus.ready = 1'b0;
            stall_left    = idle_length() - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: every decision transfer is compared with the oldest one owed.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_decisions.size() == 0) begin
            $error("decision for virtual register %0h arrived with none owed",
                   rsp_bus.out_virtual_register);
            failures++;
         end else begin
            want = pending_decisions.pop_front();
            check_field("out_virtual_register", want.vreg, rsp_bus.out_virtual_register);
            check_field("spilled", want.spilled, rsp_bus.spilled);
            check_field("physical_index", want.phys, rsp_bus.physical_index);
            check_field("out_is_float", want.is_float, rsp_bus.out_is_float);
            check_field("spill_slot", want.slot, rsp_bus.spill_slot);
            check_field("last", want.last, rsp_bus.last);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("linear_scan_register_allocator_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset                     = 1'b1;
      csr_write_enable          = 1'b0;
      csr_index                 = lsra_pkg::CSR_INT_POOL;
      csr_write_data            = '0;
      req_bus.valid             = 1'b0;
      req_bus.first_of_function = 1'b0;
      req_bus.virtual_register  = '0;
      req_bus.start_time        = '0;
      req_bus.end_time          = '0;
      req_bus.is_float          = 1'b0;

      // Reset is held while the clock runs and released at a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_field_extremes();
      test_callee_order();
      test_eviction_rules();
      test_empty_pool();
      test_random_traffic();

      // Let the last decisions drain, then give the block time to show any
      // stray transfer before the verdict.
      wait_for_decisions();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("linear_scan_register_allocator_top regression: pass");
      end else begin
         $display("linear_scan_register_allocator_top regression: fail");
      end
      $finish;
   end

endmodule
